@@ rtl/mcss_pkg.sv @@
// types, codes and constants shared by the motor calibration safety supervisor
// depends on nothing; the rtl files refer to it by scoped names, the verif files import it

package mcss_pkg;

    // stick channels are centered on this raw value
    localparam logic [11:0] STICK_CENTRE = 12'd1024;
    localparam logic [31:0] SIGN_BIT     = 32'h8000_0000;
    localparam logic [31:0] MAX_POS      = 32'h7FFF_FFFF;

    // configuration register indexes
    localparam int          CFG_INDEX_W        = 3;
    localparam logic [2:0]  CFG_MAX_ABS_RPM    = 3'd0;
    localparam logic [2:0]  CFG_MOVE_DEADBAND  = 3'd1;
    localparam logic [2:0]  CFG_YAW_DEADBAND   = 3'd2;
    localparam logic [2:0]  CFG_TIMEOUT_MS     = 3'd3;
    localparam logic [2:0]  CFG_REQUIRE_REMOTE = 3'd4;

    // configuration reset values
    localparam logic [30:0] RST_MAX_ABS_RPM    = 31'd3000;
    localparam logic [9:0]  RST_MOVE_DEADBAND  = 10'd50;
    localparam logic [9:0]  RST_YAW_DEADBAND   = 10'd50;
    localparam logic [31:0] RST_TIMEOUT_MS     = 32'd500;
    localparam logic        RST_REQUIRE_REMOTE = 1'b1;

    typedef enum logic [2:0] {
        CMD_NONE    = 3'd0,
        CMD_START   = 3'd1,
        CMD_STOP    = 3'd2,
        CMD_SET_RPM = 3'd3,
        CMD_EXIT    = 3'd4,
        CMD_INVALID = 3'd5
    } cmd_t;

    typedef enum logic [1:0] {
        MODE_IDLE   = 2'd0,
        MODE_ACTIVE = 2'd1,
        MODE_FAULT  = 2'd2
    } mode_t;

    typedef enum logic [2:0] {
        FLT_NONE       = 3'd0,
        FLT_BAD_CMD    = 3'd1,
        FLT_RPM_LIMIT  = 3'd2,
        FLT_REMOTE_OFF = 3'd3,
        FLT_OVERRIDE   = 3'd4,
        FLT_DRIVES_OFF = 3'd5,
        FLT_TIMEOUT    = 3'd6
    } fault_t;

    // one update tick
    typedef struct packed {
        logic [2:0]         command;
        logic signed [31:0] want_lf;
        logic signed [31:0] want_rf;
        logic signed [31:0] want_rb;
        logic signed [31:0] want_lb;
        logic [31:0]        now_ms;
        logic               remote_online;
        logic [10:0]        stick_y;
        logic [10:0]        stick_x;
        logic [10:0]        stick_yaw;
        logic               drives_online;
    } tick_t;

    // one result
    typedef struct packed {
        logic               drive_enable;
        logic signed [31:0] out_lf;
        logic signed [31:0] out_rf;
        logic signed [31:0] out_rb;
        logic signed [31:0] out_lb;
        logic [1:0]         mode;
        logic [2:0]         fault_code;
        logic               override_seen;
        logic [31:0]        parsed_total;
        logic [31:0]        rejected_total;
        logic [31:0]        stop_total;
        logic [31:0]        timeout_total;
    } result_t;

    // current configuration
    typedef struct packed {
        logic [30:0] max_abs_rpm;
        logic [9:0]  move_deadband;
        logic [9:0]  yaw_deadband;
        logic [31:0] timeout_ms;
        logic        require_remote;
    } cfg_t;

    // absolute value that saturates the most negative word
    function automatic logic [31:0] sat_abs(input logic [31:0] v);
        logic [31:0] r;
        if ((v & SIGN_BIT) == 32'd0) begin
            r = v;
        end
        else if (v == SIGN_BIT) begin
            r = MAX_POS;
        end
        else begin
            r = ~v + 32'd1;
        end
        return r;
    endfunction

    // true when a raw stick value lies strictly outside the band around center
    function automatic logic outside_band(input logic [10:0] raw, input logic [9:0] band);
        logic [11:0] upper;
        logic [11:0] lower;
        upper = STICK_CENTRE + {2'b00, band};
        lower = STICK_CENTRE - {2'b00, band};
        return ({1'b0, raw} > upper) || ({1'b0, raw} < lower);
    endfunction

endpackage

@@ rtl/motor_calibration_safety_supervisor_unit.sv @@
// top level of the motor calibration safety supervisor
// depends on mcss_pkg, mcss_cfg and mcss_core

// The supervisor takes one update tick per clock cycle while tick_stall is low and
// returns one result item for every tick, in order. A tick is captured in an input
// register, evaluated by single-pass logic against the supervisor state, and the
// result lands in an output register when it advances from there. Throughput is
// one item per cycle unless result_stall holds it, set by the single update stage;
// tick_stall rises only when both the input register and the output register hold
// an item and result_stall is high. Configuration writes are always accepted
// (cfg_ready is tied high) and must only be issued while no tick is in flight.

module motor_calibration_safety_supervisor_unit (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             tick_valid,
    output logic                             tick_stall,
    input  mcss_pkg::tick_t                  tick_data,
    output logic                             result_valid,
    input  logic                             result_stall,
    output mcss_pkg::result_t                result_data,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [mcss_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [31:0]                      cfg_data
);

    mcss_pkg::tick_t   tick_reg;
    logic              tick_vld_reg;
    logic              tick_vld_next;
    mcss_pkg::result_t result_reg;
    mcss_pkg::result_t core_result;
    logic              result_vld_reg;
    logic              result_vld_next;
    mcss_pkg::cfg_t    cfg;
    logic              tick_take;
    logic              advance;

    mcss_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    mcss_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .tick   (tick_reg),
        .cfg    (cfg),
        .result (core_result)
    );

    // item moves from input register to output register
    assign advance    = tick_vld_reg && (!result_vld_reg || !result_stall);
    assign tick_stall = tick_vld_reg && result_vld_reg && result_stall;
    assign tick_take  = tick_valid && !tick_stall;

    // occupancy of both registers
    always_comb
    begin
        tick_vld_next = tick_vld_reg;
        if (tick_take)
        begin
            tick_vld_next = 1'b1;
        end
        else if (advance)
        begin
            tick_vld_next = 1'b0;
        end

        result_vld_next = result_vld_reg;
        if (advance)
        begin
            result_vld_next = 1'b1;
        end
        else if (result_vld_reg && !result_stall)
        begin
            result_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_vld_reg   <= 1'b0;
            result_vld_reg <= 1'b0;
        end
        else
        begin
            tick_vld_reg   <= tick_vld_next;
            result_vld_reg <= result_vld_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (tick_take)
        begin
            tick_reg <= tick_data;
        end
        if (advance)
        begin
            result_reg <= core_result;
        end
    end

    assign result_valid = result_vld_reg;
    assign result_data  = result_reg;

endmodule

@@ rtl/mcss_cfg.sv @@
// configuration registers of the safety supervisor
// depends on mcss_pkg for index codes, reset values and cfg_t

module mcss_cfg (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [mcss_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [31:0]                      cfg_data,
    output mcss_pkg::cfg_t                   cfg
);

    mcss_pkg::cfg_t cfg_reg;
    mcss_pkg::cfg_t cfg_next;

    // writes are always taken
    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    // decode the register index, extra data bits dropped
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                mcss_pkg::CFG_MAX_ABS_RPM:    cfg_next.max_abs_rpm    = cfg_data[30:0];
                mcss_pkg::CFG_MOVE_DEADBAND:  cfg_next.move_deadband  = cfg_data[9:0];
                mcss_pkg::CFG_YAW_DEADBAND:   cfg_next.yaw_deadband   = cfg_data[9:0];
                mcss_pkg::CFG_TIMEOUT_MS:     cfg_next.timeout_ms     = cfg_data;
                mcss_pkg::CFG_REQUIRE_REMOTE: cfg_next.require_remote = cfg_data[0];
                default:                      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_abs_rpm    <= mcss_pkg::RST_MAX_ABS_RPM;
            cfg_reg.move_deadband  <= mcss_pkg::RST_MOVE_DEADBAND;
            cfg_reg.yaw_deadband   <= mcss_pkg::RST_YAW_DEADBAND;
            cfg_reg.timeout_ms     <= mcss_pkg::RST_TIMEOUT_MS;
            cfg_reg.require_remote <= mcss_pkg::RST_REQUIRE_REMOTE;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

@@ rtl/mcss_core.sv @@
// supervisor state and the per-tick update logic
// depends on mcss_pkg for tick_t, result_t, cfg_t and the mode and fault codes

module mcss_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  mcss_pkg::tick_t   tick,
    input  mcss_pkg::cfg_t    cfg,
    output mcss_pkg::result_t result
);

    mcss_pkg::mode_t   mode_reg;
    mcss_pkg::mode_t   mode_next;
    mcss_pkg::fault_t  fault_reg;
    mcss_pkg::fault_t  fault_next;
    logic [3:0][31:0]  rpm_reg;
    logic [3:0][31:0]  rpm_next;
    logic [31:0]       last_time_reg;
    logic [31:0]       last_time_next;
    logic [31:0]       parsed_reg;
    logic [31:0]       parsed_next;
    logic [31:0]       rejected_reg;
    logic [31:0]       rejected_next;
    logic [31:0]       stop_reg;
    logic [31:0]       stop_next;
    logic [31:0]       timeout_reg;
    logic [31:0]       timeout_next;

    logic [3:0][31:0]  want;
    logic [3:0]        over_limit;
    logic              rpm_ok;
    logic              over;
    logic              drive;
    logic              parsed_inc;
    logic              rejected_inc;
    logic              timeout_inc;
    logic [1:0]        stop_inc;
    logic [31:0]       elapsed;

    assign want = {tick.want_lb, tick.want_rb, tick.want_rf, tick.want_lf};

    // rpm limit check on all four wheels in parallel
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            over_limit[i] = mcss_pkg::sat_abs(want[i]) > {1'b0, cfg.max_abs_rpm};
        end
    end

    assign rpm_ok = ~|over_limit;

    // stick deadband checks
    assign over = mcss_pkg::outside_band(tick.stick_y, cfg.move_deadband)
               || mcss_pkg::outside_band(tick.stick_x, cfg.move_deadband)
               || mcss_pkg::outside_band(tick.stick_yaw, cfg.yaw_deadband);

    // command handling, then the safety checks while active
    always_comb
    begin
        mode_next      = mode_reg;
        fault_next     = fault_reg;
        rpm_next       = rpm_reg;
        last_time_next = last_time_reg;
        parsed_inc     = 1'b0;
        rejected_inc   = 1'b0;
        timeout_inc    = 1'b0;
        stop_inc       = 2'd0;
        drive          = 1'b0;
        elapsed        = '0;

        if (mcss_pkg::cmd_t'(tick.command) != mcss_pkg::CMD_NONE)
        begin
            parsed_inc = 1'b1;
            unique case (mcss_pkg::cmd_t'(tick.command))
                mcss_pkg::CMD_START:
                begin
                    rpm_next       = '0;
                    mode_next      = mcss_pkg::MODE_ACTIVE;
                    fault_next     = mcss_pkg::FLT_NONE;
                    last_time_next = tick.now_ms;
                end
                mcss_pkg::CMD_STOP:
                begin
                    rpm_next       = '0;
                    last_time_next = tick.now_ms;
                    stop_inc       = 2'd1;
                end
                mcss_pkg::CMD_SET_RPM:
                begin
                    priority if (mode_reg != mcss_pkg::MODE_ACTIVE)
                    begin
                        rejected_inc = 1'b1;
                        rpm_next     = '0;
                        mode_next    = mcss_pkg::MODE_FAULT;
                        fault_next   = mcss_pkg::FLT_BAD_CMD;
                        stop_inc     = 2'd1;
                    end
                    else if (!rpm_ok)
                    begin
                        rejected_inc = 1'b1;
                        rpm_next     = '0;
                        mode_next    = mcss_pkg::MODE_FAULT;
                        fault_next   = mcss_pkg::FLT_RPM_LIMIT;
                        stop_inc     = 2'd1;
                    end
                    else
                    begin
                        rpm_next       = want;
                        last_time_next = tick.now_ms;
                    end
                end
                mcss_pkg::CMD_EXIT:
                begin
                    rpm_next       = '0;
                    mode_next      = mcss_pkg::MODE_IDLE;
                    fault_next     = mcss_pkg::FLT_NONE;
                    last_time_next = tick.now_ms;
                end
                // invalid and unused codes
                default:
                begin
                    rejected_inc = 1'b1;
                    rpm_next     = '0;
                    mode_next    = mcss_pkg::MODE_FAULT;
                    fault_next   = mcss_pkg::FLT_BAD_CMD;
                    stop_inc     = 2'd1;
                end
            endcase
        end

        // wrapping time since the last accepted command
        elapsed = tick.now_ms - last_time_next;

        if (mode_next == mcss_pkg::MODE_ACTIVE)
        begin
            priority if (cfg.require_remote && !tick.remote_online)
            begin
                fault_next = mcss_pkg::FLT_REMOTE_OFF;
            end
            else if (over)
            begin
                fault_next = mcss_pkg::FLT_OVERRIDE;
            end
            else if (!tick.drives_online)
            begin
                fault_next = mcss_pkg::FLT_DRIVES_OFF;
            end
            else if (elapsed > cfg.timeout_ms)
            begin
                fault_next  = mcss_pkg::FLT_TIMEOUT;
                timeout_inc = 1'b1;
            end
            else
            begin
                drive = 1'b1;
            end

            // any failed check stops everything
            if (!drive)
            begin
                rpm_next  = '0;
                mode_next = mcss_pkg::MODE_FAULT;
                stop_inc  = stop_inc + 2'd1;
            end
        end

        parsed_next   = parsed_reg + {31'd0, parsed_inc};
        rejected_next = rejected_reg + {31'd0, rejected_inc};
        stop_next     = stop_reg + {30'd0, stop_inc};
        timeout_next  = timeout_reg + {31'd0, timeout_inc};
    end

    // result of this tick
    always_comb
    begin
        result.drive_enable   = drive;
        result.out_lf         = drive ? rpm_next[0] : '0;
        result.out_rf         = drive ? rpm_next[1] : '0;
        result.out_rb         = drive ? rpm_next[2] : '0;
        result.out_lb         = drive ? rpm_next[3] : '0;
        result.mode           = mode_next;
        result.fault_code     = fault_next;
        result.override_seen  = over;
        result.parsed_total   = parsed_next;
        result.rejected_total = rejected_next;
        result.stop_total     = stop_next;
        result.timeout_total  = timeout_next;
    end

    // state advances once per tick
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= mcss_pkg::MODE_IDLE;
            fault_reg     <= mcss_pkg::FLT_NONE;
            rpm_reg       <= '0;
            last_time_reg <= '0;
            parsed_reg    <= '0;
            rejected_reg  <= '0;
            stop_reg      <= '0;
            timeout_reg   <= '0;
        end
        else if (step)
        begin
            mode_reg      <= mode_next;
            fault_reg     <= fault_next;
            rpm_reg       <= rpm_next;
            last_time_reg <= last_time_next;
            parsed_reg    <= parsed_next;
            rejected_reg  <= rejected_next;
            stop_reg      <= stop_next;
            timeout_reg   <= timeout_next;
        end
    end

endmodule

@@ verif/mcss_checker.sv @@
// result checker for the motor calibration safety supervisor: follows the tick,
// result and register channels, predicts every result item and compares it
// depends on mcss_pkg

module mcss_checker (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             tick_valid,
    input  logic                             tick_stall,
    input  mcss_pkg::tick_t                  tick_data,
    input  logic                             result_valid,
    input  logic                             result_stall,
    input  mcss_pkg::result_t                result_data,
    input  logic                             cfg_valid,
    input  logic                             cfg_ready,
    input  logic [mcss_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [31:0]                      cfg_data,
    output int                               mismatch_count,
    output int                               results_due
);
    import mcss_pkg::*;

    // settings as the block holds them
    logic [30:0] lim_rpm;
    logic [9:0]  band_move;
    logic [9:0]  band_yaw;
    logic [31:0] limit_ms;
    logic        need_remote;

    // supervisor state as predicted
    mode_t       sv_mode;
    fault_t      sv_fault;
    logic [31:0] sv_rpm [4];
    logic [31:0] last_cmd_ms;
    logic [31:0] cnt_parsed;
    logic [31:0] cnt_rejected;
    logic [31:0] cnt_stops;
    logic [31:0] cnt_timeouts;

    result_t     pending_results [$];
    result_t     oldest;
    int          mismatches;

    // magnitude of a two's complement word, most negative word saturates
    function automatic logic [31:0] rpm_magnitude(input logic [31:0] w);
        if (!w[31]) return w;
        if (w == SIGN_BIT) return MAX_POS;
        return -w;
    endfunction

    // strictly outside the band around stick center
    function automatic logic stick_deflected(input logic [10:0] raw, input logic [9:0] band);
        int d;
        int b;
        d = int'(raw) - int'(STICK_CENTRE);
        b = int'(band);
        return (d > b) || (d < -b);
    endfunction

    function automatic void clear_targets();
        for (int i = 0; i < 4; i++) sv_rpm[i] = '0;
    endfunction

    // fault entry: stop everything and latch the code
    function automatic void trip(input fault_t code);
        clear_targets();
        sv_mode   = MODE_FAULT;
        sv_fault  = code;
        cnt_stops = cnt_stops + 32'd1;
    endfunction

    // one update tick: consume the command, then run the safety checks
    function automatic result_t supervise(input tick_t t);
        result_t     r;
        logic [31:0] want [4];
        logic [31:0] elapsed;
        logic        in_limit;
        logic        over;
        logic        drive;
        want[0] = t.want_lf;
        want[1] = t.want_rf;
        want[2] = t.want_rb;
        want[3] = t.want_lb;
        drive = 1'b0;

        if (t.command != CMD_NONE)
        begin
            cnt_parsed = cnt_parsed + 32'd1;
            case (t.command)
                CMD_START:
                begin
                    clear_targets();
                    sv_mode     = MODE_ACTIVE;
                    sv_fault    = FLT_NONE;
                    last_cmd_ms = t.now_ms;
                end
                CMD_STOP:
                begin
                    clear_targets();
                    last_cmd_ms = t.now_ms;
                    cnt_stops   = cnt_stops + 32'd1;
                end
                CMD_SET_RPM:
                begin
                    in_limit = 1'b1;
                    for (int i = 0; i < 4; i++)
                        if (rpm_magnitude(want[i]) > {1'b0, lim_rpm}) in_limit = 1'b0;
                    if (sv_mode != MODE_ACTIVE)
                    begin
                        cnt_rejected = cnt_rejected + 32'd1;
                        trip(FLT_BAD_CMD);
                    end
                    else if (!in_limit)
                    begin
                        cnt_rejected = cnt_rejected + 32'd1;
                        trip(FLT_RPM_LIMIT);
                    end
                    else
                    begin
                        for (int i = 0; i < 4; i++) sv_rpm[i] = want[i];
                        last_cmd_ms = t.now_ms;
                    end
                end
                CMD_EXIT:
                begin
                    clear_targets();
                    sv_mode     = MODE_IDLE;
                    sv_fault    = FLT_NONE;
                    last_cmd_ms = t.now_ms;
                end
                default:
                begin
                    // invalid and the two unused codes
                    cnt_rejected = cnt_rejected + 32'd1;
                    trip(FLT_BAD_CMD);
                end
            endcase
        end

        over = stick_deflected(t.stick_y, band_move) ||
               stick_deflected(t.stick_x, band_move) ||
               stick_deflected(t.stick_yaw, band_yaw);

        // checks in priority order while active
        elapsed = t.now_ms - last_cmd_ms;
        if (sv_mode == MODE_ACTIVE)
        begin
            if (need_remote && !t.remote_online) trip(FLT_REMOTE_OFF);
            else if (over) trip(FLT_OVERRIDE);
            else if (!t.drives_online) trip(FLT_DRIVES_OFF);
            else if (elapsed > limit_ms)
            begin
                cnt_timeouts = cnt_timeouts + 32'd1;
                trip(FLT_TIMEOUT);
            end
            else drive = 1'b1;
        end

        r.drive_enable   = drive;
        r.out_lf         = drive ? sv_rpm[0] : '0;
        r.out_rf         = drive ? sv_rpm[1] : '0;
        r.out_rb         = drive ? sv_rpm[2] : '0;
        r.out_lb         = drive ? sv_rpm[3] : '0;
        r.mode           = sv_mode;
        r.fault_code     = sv_fault;
        r.override_seen  = over;
        r.parsed_total   = cnt_parsed;
        r.rejected_total = cnt_rejected;
        r.stop_total     = cnt_stops;
        r.timeout_total  = cnt_timeouts;
        return r;
    endfunction

    function automatic void check_field(input string fname, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: %s mismatch, expected %0h, got %0h", $realtime, fname, want, got);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lim_rpm      = RST_MAX_ABS_RPM;
            band_move    = RST_MOVE_DEADBAND;
            band_yaw     = RST_YAW_DEADBAND;
            limit_ms     = RST_TIMEOUT_MS;
            need_remote  = RST_REQUIRE_REMOTE;
            sv_mode      = MODE_IDLE;
            sv_fault     = FLT_NONE;
            clear_targets();
            last_cmd_ms  = '0;
            cnt_parsed   = '0;
            cnt_rejected = '0;
            cnt_stops    = '0;
            cnt_timeouts = '0;
            pending_results.delete();
            mismatches   = 0;
        end
        else
        begin
            // register writes, only seen while the block is idle
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_MAX_ABS_RPM:    lim_rpm     = cfg_data[30:0];
                    CFG_MOVE_DEADBAND:  band_move   = cfg_data[9:0];
                    CFG_YAW_DEADBAND:   band_yaw    = cfg_data[9:0];
                    CFG_TIMEOUT_MS:     limit_ms    = cfg_data;
                    CFG_REQUIRE_REMOTE: need_remote = cfg_data[0];
                    default:            ;
                endcase
            end

            // compare each result item with the oldest prediction
            if (result_valid && !result_stall)
            begin
                if (pending_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: result item with nothing expected", $realtime);
                end
                else
                begin
                    oldest = pending_results.pop_front();
                    check_field("drive_enable", 32'(oldest.drive_enable),
                                32'(result_data.drive_enable));
                    check_field("out_lf", oldest.out_lf, result_data.out_lf);
                    check_field("out_rf", oldest.out_rf, result_data.out_rf);
                    check_field("out_rb", oldest.out_rb, result_data.out_rb);
                    check_field("out_lb", oldest.out_lb, result_data.out_lb);
                    check_field("mode", 32'(oldest.mode), 32'(result_data.mode));
                    check_field("fault_code", 32'(oldest.fault_code),
                                32'(result_data.fault_code));
                    check_field("override_seen", 32'(oldest.override_seen),
                                32'(result_data.override_seen));
                    check_field("parsed_total", oldest.parsed_total,
                                result_data.parsed_total);
                    check_field("rejected_total", oldest.rejected_total,
                                result_data.rejected_total);
                    check_field("stop_total", oldest.stop_total, result_data.stop_total);
                    check_field("timeout_total", oldest.timeout_total,
                                result_data.timeout_total);
                end
            end

            // predict the result of each accepted tick
            if (tick_valid && !tick_stall) pending_results.push_back(supervise(tick_data));
        end
        mismatch_count <= mismatches;
        results_due    <= pending_results.size();
    end

endmodule

@@ verif/motor_calibration_safety_supervisor_unit_tb.sv @@
// testbench top for the motor calibration safety supervisor: directed and random
// update ticks under several register settings, random idling on both sides
// depends on mcss_pkg, mcss_checker and the supervisor rtl

module motor_calibration_safety_supervisor_unit_tb;
    import mcss_pkg::*;

    localparam int STALL_LIMIT = 4000;
    localparam int LONG_HOLD   = 400;

    logic                   clk          = 1'b0;
    logic                   rst_n        = 1'b0;
    logic                   tick_valid   = 1'b0;
    logic                   tick_stall;
    tick_t                  tick_data    = '0;
    logic                   result_valid;
    logic                   result_stall = 1'b0;
    result_t                result_data;
    logic                   cfg_valid    = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index    = '0;
    logic [31:0]            cfg_data     = '0;
    int                     mismatch_count;
    int                     results_due;

    // current settings, used only to shape the stimulus
    logic [30:0] set_limit   = RST_MAX_ABS_RPM;
    logic [9:0]  set_move    = RST_MOVE_DEADBAND;
    logic [9:0]  set_yaw     = RST_YAW_DEADBAND;
    logic [31:0] set_timeout = RST_TIMEOUT_MS;

    logic [31:0] clock_ms    = '0;
    bit          calm        = 1'b0;
    bit          hold_wanted = 1'b0;

    motor_calibration_safety_supervisor_unit uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .tick_valid   (tick_valid),
        .tick_stall   (tick_stall),
        .tick_data    (tick_data),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_data  (result_data),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    mcss_checker supervisor_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .tick_valid     (tick_valid),
        .tick_stall     (tick_stall),
        .tick_data      (tick_data),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .result_data    (result_data),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatch_count),
        .results_due    (results_due)
    );

    always #2 clk = ~clk;

    function automatic int draw_pause();
        return calm ? 0 : $urandom_range(0, 13);
    endfunction

    // centered sticks, links up
    function automatic tick_t quiet_tick(input cmd_t code, input logic [31:0] at_ms);
        tick_t t;
        t = '0;
        t.command       = code;
        t.now_ms        = at_ms;
        t.remote_online = 1'b1;
        t.drives_online = 1'b1;
        t.stick_y       = 11'(STICK_CENTRE);
        t.stick_x       = 11'(STICK_CENTRE);
        t.stick_yaw     = 11'(STICK_CENTRE);
        return t;
    endfunction

    // mostly within the limit, sometimes on or past it
    function automatic logic [31:0] pick_rpm();
        int          pick;
        logic [31:0] mag;
        pick = $urandom_range(0, 99);
        if (pick < 90) mag = $urandom_range(0, set_limit);
        else if (pick < 94) mag = {1'b0, set_limit};
        else if (pick < 96) mag = {1'b0, set_limit} + 32'd1;
        else if (pick < 98) return $urandom_range(0, 1) ? SIGN_BIT : MAX_POS;
        else return $urandom;
        return $urandom_range(0, 1) ? -mag : mag;
    endfunction

    // mostly inside the deadband, sometimes on or just past its edge, or anywhere
    function automatic logic [10:0] pick_stick(input logic [9:0] band);
        int pick;
        int off;
        int raw;
        pick = $urandom_range(0, 99);
        if (pick < 97) off = $urandom_range(0, band);
        else if (pick < 99) off = int'(band) + $urandom_range(0, 1);
        else return 11'($urandom_range(0, 2047));
        raw = $urandom_range(0, 1) ? int'(STICK_CENTRE) + off : int'(STICK_CENTRE) - off;
        if (raw > 2047) raw = 2047;
        if (raw < 0) raw = 0;
        return 11'(raw);
    endfunction

    function automatic tick_t random_tick();
        tick_t       t;
        int          pick;
        logic [31:0] span;
        t = '0;
        pick = $urandom_range(0, 99);
        if (pick < 55) t.command = CMD_NONE;
        else if (pick < 67) t.command = CMD_START;
        else if (pick < 71) t.command = CMD_STOP;
        else if (pick < 93) t.command = CMD_SET_RPM;
        else if (pick < 96) t.command = CMD_EXIT;
        else t.command = CMD_INVALID + 3'($urandom_range(0, 2));
        t.want_lf = pick_rpm();
        t.want_rf = pick_rpm();
        t.want_rb = pick_rpm();
        t.want_lb = pick_rpm();

        // time moves mostly inside the timeout, now and then onto or just past its edge, or jumps anywhere
        span = (set_timeout > 32'd40) ? set_timeout >> 3 : set_timeout;
        pick = $urandom_range(0, 99);
        if (pick < 88) clock_ms = clock_ms + $urandom_range(0, span);
        else if (pick < 93) clock_ms = clock_ms + set_timeout;
        else if (pick < 97) clock_ms = clock_ms + set_timeout + 32'd1;
        else clock_ms = $urandom;
        t.now_ms = clock_ms;

        t.remote_online = ($urandom_range(0, 99) >= 2);
        t.drives_online = ($urandom_range(0, 99) >= 2);
        t.stick_y       = pick_stick(set_move);
        t.stick_x       = pick_stick(set_move);
        t.stick_yaw     = pick_stick(set_yaw);
        return t;
    endfunction

    // present one item and hold it until taken
    task automatic offer_tick(input tick_t t);
        int pause;
        pause = draw_pause();
        if (pause > 0)
        begin
            tick_valid <= 1'b0;
            repeat (pause) @(posedge clk);
        end
        tick_valid <= 1'b1;
        tick_data  <= t;
        @(posedge clk);
        while (tick_stall) @(posedge clk);
    endtask

    task automatic run_random(input int count);
        for (int n = 0; n < count; n++)
        begin
            if (n % 50 == 0) calm = ($urandom_range(0, 3) == 0);
            offer_tick(random_tick());
        end
    endtask

    // stop sending and wait until every result item is back
    task automatic drain();
        tick_valid <= 1'b0;
        @(posedge clk);
        while (results_due != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        case (idx)
            CFG_MAX_ABS_RPM:   set_limit   = value[30:0];
            CFG_MOVE_DEADBAND: set_move    = value[9:0];
            CFG_YAW_DEADBAND:  set_yaw     = value[9:0];
            CFG_TIMEOUT_MS:    set_timeout = value;
            default:           ;
        endcase
    endtask

    // all five registers, then a write to an unused index that must be ignored
    task automatic apply_settings(input logic [31:0] limit, input logic [31:0] move_band,
                                  input logic [31:0] yaw_band, input logic [31:0] timeout,
                                  input logic [31:0] remote);
        write_reg(CFG_MAX_ABS_RPM, limit);
        write_reg(CFG_MOVE_DEADBAND, move_band);
        write_reg(CFG_YAW_DEADBAND, yaw_band);
        write_reg(CFG_TIMEOUT_MS, timeout);
        write_reg(CFG_REQUIRE_REMOTE, remote);
        write_reg(CFG_REQUIRE_REMOTE + 3'($urandom_range(1, 3)), $urandom);
        cfg_valid <= 1'b0;
    endtask

    // result side: random hold-offs, one long one on request
    initial
    begin
        int pause;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (hold_wanted)
            begin
                hold_wanted = 1'b0;
                pause = LONG_HOLD;
            end
            else pause = draw_pause();
            if (pause > 0)
            begin
                result_stall <= 1'b1;
                repeat (pause) @(posedge clk);
            end
            result_stall <= 1'b0;
            @(posedge clk);
            while (!result_valid) @(posedge clk);
        end
    end

    // watchdog on cycles with no handshake at all
    initial
    begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((tick_valid && !tick_stall) || (result_valid && !result_stall) ||
                (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("[motor_calibration_safety_supervisor_unit] ERROR");
        $finish;
    end

    // stimulus
    initial
    begin
        tick_t t;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // idle, then set rpm while idle is a bad command
        offer_tick(quiet_tick(CMD_NONE, 32'd0));
        t = quiet_tick(CMD_SET_RPM, 32'd1);
        t.want_lf = 100;
        offer_tick(t);
        // start, drive at the limit, timeout edge
        offer_tick(quiet_tick(CMD_START, 32'd10));
        t = quiet_tick(CMD_SET_RPM, 32'd20);
        t.want_lf = 3000;
        t.want_rf = -3000;
        t.want_rb = 0;
        t.want_lb = -1;
        offer_tick(t);
        offer_tick(quiet_tick(CMD_NONE, 32'd520));
        offer_tick(quiet_tick(CMD_NONE, 32'd521));
        // one past the limit, and the most negative rpm
        offer_tick(quiet_tick(CMD_START, 32'd600));
        t = quiet_tick(CMD_SET_RPM, 32'd610);
        t.want_rf = 3001;
        offer_tick(t);
        offer_tick(quiet_tick(CMD_START, 32'd620));
        t = quiet_tick(CMD_SET_RPM, 32'd630);
        t.want_lb = SIGN_BIT;
        offer_tick(t);
        // sticks on the deadband edge, then just past it
        offer_tick(quiet_tick(CMD_START, 32'd640));
        t = quiet_tick(CMD_NONE, 32'd641);
        t.stick_y = 11'(STICK_CENTRE) + 11'd50;
        t.stick_x = 11'(STICK_CENTRE) - 11'd50;
        offer_tick(t);
        t = quiet_tick(CMD_NONE, 32'd642);
        t.stick_yaw = 11'(STICK_CENTRE) + 11'd51;
        offer_tick(t);
        // remote and drives offline
        offer_tick(quiet_tick(CMD_START, 32'd650));
        t = quiet_tick(CMD_NONE, 32'd651);
        t.remote_online = 1'b0;
        offer_tick(t);
        offer_tick(quiet_tick(CMD_START, 32'd660));
        t = quiet_tick(CMD_NONE, 32'd661);
        t.drives_online = 1'b0;
        offer_tick(t);
        // time wraps across zero, stop output keeps the mode, exit goes idle
        offer_tick(quiet_tick(CMD_START, 32'hFFFF_FF00));
        offer_tick(quiet_tick(CMD_NONE, 32'h0000_00F4));
        offer_tick(quiet_tick(CMD_STOP, 32'h0000_0100));
        offer_tick(quiet_tick(CMD_EXIT, 32'h0000_0110));
        // invalid and the two unused codes
        offer_tick(quiet_tick(CMD_INVALID, 32'h0000_0111));
        t = quiet_tick(CMD_INVALID, 32'h0000_0112);
        t.command = CMD_INVALID + 3'd1;
        offer_tick(t);
        t.command = CMD_INVALID + 3'd2;
        offer_tick(t);
        // sticks at both ends while not active
        t = quiet_tick(CMD_NONE, 32'h0000_0113);
        t.stick_y   = 11'd0;
        t.stick_x   = 11'd2047;
        t.stick_yaw = 11'd0;
        offer_tick(t);
        clock_ms = 32'h0000_0113;
        run_random(150);
        drain();

        // everything at its low end
        apply_settings(32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
        run_random(200);
        drain();

        // everything at its high end, with one long hold-off on the result side
        apply_settings(32'hFFFF_FFFF, 32'd1023, 32'd1023, 32'hFFFF_FFFF, 32'd1);
        hold_wanted = 1'b1;
        run_random(200);
        drain();

        // random settings, short timeout
        apply_settings($urandom, $urandom, $urandom, $urandom_range(0, 5000), $urandom);
        run_random(220);
        drain();

        // random settings throughout
        apply_settings($urandom, $urandom, $urandom, $urandom, $urandom);
        run_random(220);
        drain();

        // back to the power-on settings
        apply_settings(32'(RST_MAX_ABS_RPM), 32'(RST_MOVE_DEADBAND), 32'(RST_YAW_DEADBAND),
                       RST_TIMEOUT_MS, 32'(RST_REQUIRE_REMOTE));
        run_random(200);
        drain();

        if (mismatch_count == 0)
            $display("[motor_calibration_safety_supervisor_unit] OK");
        else
            $display("[motor_calibration_safety_supervisor_unit] ERROR");
        $finish;
    end

endmodule
